[rtl/rss_pkg.sv]
// ----------------------------------------------------------------------------
// rss_pkg: shared types and codes for running sample statistics
// Word layouts of both queue-style ports, request codes, back-end states and
// default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

  // Default sizes
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 16;
  // Depth of the report queue between front and back end
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Request codes
  localparam logic [1:0] REQ_ADD        = 2'd0;
  localparam logic [1:0] REQ_ADD_REPORT = 2'd1;
  localparam logic [1:0] REQ_REPORT     = 2'd2;

  // Input word
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] sample;
  } rss_in_t;

  // Result word
  typedef struct packed {
    logic [15:0]        sample_count;
    logic signed [15:0] mean_value;
    logic [15:0]        std_deviation;
    logic signed [15:0] min_value;
    logic signed [15:0] max_value;
    logic               empty_set;
    logic               overflow_seen;
  } rss_out_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_SUM,
    ST_DIV_SQ,
    ST_VAR,
    ST_ROOT,
    ST_DONE
  } back_state_e;

endpackage

`default_nettype wire

[rtl/rss_front.sv]
// ----------------------------------------------------------------------------
// rss_front: sample intake and accumulation
// Registers each input word, folds samples into count, sum, sum of squares,
// minimum and maximum, and on a report pushes a snapshot and clears.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_front #(
  parameter int unsigned SAMPLE_BITS = rss_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rss_pkg::COUNT_BITS_DEF,
  parameter int unsigned SNAP_W      = 5 * SAMPLE_BITS + 3 * COUNT_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire rss_pkg::rss_in_t    data_i,
  output logic [SNAP_W-1:0]        snap_o,
  output logic                     snap_push_o,
  input  wire logic                snap_full_i
);
  import rss_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned CB     = COUNT_BITS;
  localparam int unsigned SUM_W  = SB + CB;
  localparam int unsigned SQ_W   = 2 * SB - 1 + CB;
  localparam int unsigned PROD_W = 2 * SB;

  typedef struct packed {
    logic [CB-1:0]           count;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic signed [SB-1:0]    lo;
    logic signed [SB-1:0]    hi;
    logic                    drop;
  } snap_t;

  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
  localparam snap_t CLEAR = '{count: '0, sum: '0, sumsq: '0, lo: SMAX, hi: SMIN, drop: 1'b0};

  rss_in_t              item_q;
  logic                 vld_q, vld_d;
  snap_t                acc_q, acc_d, upd;
  logic                 is_add, is_rpt, go;
  logic [SB+15:0]       raw_ext;
  logic signed [SB-1:0] smp;
  logic signed [PROD_W-1:0] prod;

  // Decode the request code; the unused code reports only
  always_comb begin
    case (item_q.req_type)
      REQ_ADD: begin
        is_add = 1'b1;
        is_rpt = 1'b0;
      end
      REQ_ADD_REPORT: begin
        is_add = 1'b1;
        is_rpt = 1'b1;
      end
      REQ_REPORT: begin
        is_add = 1'b0;
        is_rpt = 1'b1;
      end
      default: begin
        is_add = 1'b0;
        is_rpt = 1'b1;
      end
    endcase
  end

  // Stall a report word while the queue is full
  assign go          = !(is_rpt && snap_full_i);
  assign full        = vld_q && !go;
  assign snap_push_o = vld_q && is_rpt && !snap_full_i;

  // Reinterpret the sample field at the configured width
  assign raw_ext = {{SB{1'b0}}, item_q.sample};
  assign smp     = $signed(raw_ext[SB-1:0]);
  assign prod    = smp * smp;

  // Fold the sample in, or only flag it at the count limit
  always_comb begin
    upd = acc_q;
    if (is_add) begin
      if (acc_q.count == {CB{1'b1}}) begin
        upd.drop = 1'b1;
      end else begin
        upd.count = acc_q.count + 1'b1;
        upd.sum   = acc_q.sum + {{CB{smp[SB-1]}}, smp};
        upd.sumsq = acc_q.sumsq + {{CB{1'b0}}, prod[PROD_W-2:0]};
        if (smp < acc_q.lo) begin
          upd.lo = smp;
        end
        if (smp > acc_q.hi) begin
          upd.hi = smp;
        end
      end
    end
    snap_o = upd;
    acc_d  = acc_q;
    if (vld_q && go) begin
      acc_d = is_rpt ? CLEAR : upd;
    end
  end

  // Advance the input register
  always_comb begin
    vld_d = vld_q;
    if (vld_q && go) begin
      vld_d = 1'b0;
    end
    if (push && !full) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      acc_q <= CLEAR;
    end else begin
      vld_q <= vld_d;
      acc_q <= acc_d;
    end
  end

  // Hold the input word
  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      item_q <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/rss_queue.sv]
// ----------------------------------------------------------------------------
// rss_queue: short report queue
// Holds accumulator snapshots between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = rss_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);
  import rss_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full report queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty report queue");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (!empty_o && cnt_q == $past(cnt_q) + 1'b1))
    else $error("report queue level did not follow a push");

endmodule

`default_nettype wire

[rtl/rss_div.sv]
// ----------------------------------------------------------------------------
// rss_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_div #(
  parameter int unsigned NUM_W = 47,
  parameter int unsigned DEN_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o,
  output logic [DEN_W-1:0]      rem_o
);
  import rss_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  // Trial subtract of the shifted remainder
  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in, keep the partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/rss_back.sv]
// ----------------------------------------------------------------------------
// rss_back: report back end
// Takes a snapshot, divides for mean and mean square, takes the floor square
// root of the variance and holds the result word until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_back #(
  parameter int unsigned SAMPLE_BITS = rss_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rss_pkg::COUNT_BITS_DEF,
  parameter int unsigned SNAP_W      = 5 * SAMPLE_BITS + 3 * COUNT_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SNAP_W-1:0] snap_i,
  input  wire logic              snap_empty_i,
  output logic                   snap_pop_o,
  output rss_pkg::rss_out_t      data_o,
  output logic                   empty,
  input  wire logic              pop
);
  import rss_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned CB     = COUNT_BITS;
  localparam int unsigned SUM_W  = SB + CB;
  localparam int unsigned SQ_W   = 2 * SB - 1 + CB;
  localparam int unsigned RAD_W  = 2 * SB;
  localparam int unsigned STEP_W = $clog2(SB);

  typedef struct packed {
    logic [CB-1:0]           count;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic signed [SB-1:0]    lo;
    logic signed [SB-1:0]    hi;
    logic                    drop;
  } snap_t;

  back_state_e          state_q, state_d;
  snap_t                snap_q;
  logic signed [SB-1:0] mean_q;
  logic [SQ_W-1:0]      meansq_q;
  logic [RAD_W-1:0]     msq_q, rad_q, root_q, bit_q, trial;
  logic [STEP_W-1:0]    step_q;
  rss_out_t             res_q, res_new;
  logic                 res_vld_q, res_load;

  logic                     div_start, div_done;
  logic [SQ_W-1:0]          div_num, div_quo;
  logic [CB-1:0]            div_rem;
  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_abs, mean_w;
  logic signed [RAD_W-1:0]  mean_prod;
  logic [SQ_W-1:0]          msq_ext;
  logic [SB+15:0]           mean_ext, lo_ext, hi_ext, root_ext, cnt_ext;

  rss_div #(
    .NUM_W (SQ_W),
    .DEN_W (CB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (snap_q.count),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // Magnitude of the sum and floored signed quotient
  assign sum_neg = snap_q.sum[SUM_W-1];
  assign sum_abs = sum_neg ? (SUM_W'(0) - snap_q.sum) : snap_q.sum;
  always_comb begin
    mean_w = div_quo[SUM_W-1:0];
    if (sum_neg) begin
      mean_w = SUM_W'(0) - (div_quo[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, (div_rem != '0)});
    end
  end

  assign mean_prod = mean_q * mean_q;
  assign msq_ext   = {{(SQ_W-RAD_W){1'b0}}, msq_q};
  assign trial     = root_q + bit_q;
  assign res_load  = (state_q == ST_DONE) && (!res_vld_q || pop);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!snap_empty_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = (snap_q.count == '0) ? ST_DONE : ST_DIV_SUM;
      end
      ST_DIV_SUM: begin
        if (div_done) begin
          state_d = ST_DIV_SQ;
        end
      end
      ST_DIV_SQ: begin
        if (div_done) begin
          state_d = ST_VAR;
        end
      end
      ST_VAR: begin
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (step_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_vld_q || pop) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    snap_pop_o = 1'b0;
    div_start  = 1'b0;
    div_num    = {{(SQ_W-SUM_W){1'b0}}, sum_abs};
    case (state_q)
      ST_IDLE: begin
        snap_pop_o = !snap_empty_i;
      end
      ST_START: begin
        div_start = (snap_q.count != '0);
      end
      ST_DIV_SUM: begin
        div_start = div_done;
        div_num   = snap_q.sumsq;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Assemble the result word; an empty set reports zeros
  always_comb begin
    cnt_ext  = {{(SB+16-CB){1'b0}}, snap_q.count};
    mean_ext = {{16{mean_q[SB-1]}}, mean_q};
    lo_ext   = {{16{snap_q.lo[SB-1]}}, snap_q.lo};
    hi_ext   = {{16{snap_q.hi[SB-1]}}, snap_q.hi};
    root_ext = {16'b0, root_q[SB-1:0]};
    res_new.sample_count  = cnt_ext[15:0];
    res_new.empty_set     = (snap_q.count == '0);
    res_new.overflow_seen = snap_q.drop;
    if (snap_q.count == '0) begin
      res_new.mean_value    = '0;
      res_new.std_deviation = '0;
      res_new.min_value     = '0;
      res_new.max_value     = '0;
    end else begin
      res_new.mean_value    = mean_ext[15:0];
      res_new.std_deviation = root_ext[15:0];
      res_new.min_value     = lo_ext[15:0];
      res_new.max_value     = hi_ext[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (pop) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (snap_pop_o) begin
      snap_q <= snap_i;
    end
    if (state_q == ST_DIV_SUM && div_done) begin
      mean_q <= mean_w[SB-1:0];
    end
    if (state_q == ST_DIV_SQ && div_done) begin
      meansq_q <= div_quo;
      msq_q    <= mean_prod;
    end
    // Clamp a negative variance to zero and seed the root
    if (state_q == ST_VAR) begin
      rad_q  <= (meansq_q > msq_ext) ? RAD_W'(meansq_q - msq_ext) : '0;
      root_q <= '0;
      bit_q  <= {2'b01, {(RAD_W-2){1'b0}}};
      step_q <= STEP_W'(SB - 1);
    end
    // One root bit per cycle
    if (state_q == ST_ROOT) begin
      if (rad_q >= trial) begin
        rad_q  <= rad_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q  <= bit_q >> 2;
      step_q <= step_q - 1'b1;
    end
    if (res_load) begin
      res_q <= res_new;
    end
  end

  assign data_o = res_q;
  assign empty  = !res_vld_q;

endmodule

`default_nettype wire

[rtl/running_sample_statistics.sv]
// ----------------------------------------------------------------------------
// running_sample_statistics: running count, mean, deviation, min and max
// Input words are pushed like into a queue (push/full); each carries a request
// code and a signed Q7.8 sample. Result words are taken like from a queue
// (empty/pop); a report word yields one result, an add word none.
// An add word is taken every cycle unless a stalled report word waits ahead
// of it: a one-word input register feeds a single accumulate step (square,
// add, two compares). A report snapshots and clears the accumulators in that
// same step and moves on through a two-entry queue. The back end works one
// report at a time: two restoring divisions with 2*SAMPLE_BITS+COUNT_BITS-1
// quotient bits each, one bit per cycle, then a square root of SAMPLE_BITS
// result bits; an empty set skips the divisions and the root. It takes the
// next report only when the current one is done; the divisions and root
// bound how often it takes a report; sample intake continues meanwhile.
// Reset empties every register stage and clears the accumulators. While the
// result is not popped it stays on the ports; the back end then waits, the
// queue fills, and full rises only when a further report word must wait.
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics #(
  parameter int unsigned SAMPLE_BITS = rss_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rss_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire rss_pkg::rss_in_t  data_i,
  output logic                   empty,
  input  wire logic              pop,
  output rss_pkg::rss_out_t      data_o
);
  import rss_pkg::*;

  localparam int unsigned SNAP_W = 5 * SAMPLE_BITS + 3 * COUNT_BITS;

  logic [SNAP_W-1:0] snap_in, snap_out;
  logic              snap_push, snap_full, snap_pop, snap_empty;

  // Intake and accumulation
  rss_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .SNAP_W      (SNAP_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_i      (data_i),
    .snap_o      (snap_in),
    .snap_push_o (snap_push),
    .snap_full_i (snap_full)
  );

  // Report snapshots in flight
  rss_queue #(
    .WIDTH (SNAP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .full_o  (snap_full),
    .pop_i   (snap_pop),
    .data_o  (snap_out),
    .empty_o (snap_empty)
  );

  // Division, root and result register
  rss_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .SNAP_W      (SNAP_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_i       (snap_out),
    .snap_empty_i (snap_empty),
    .snap_pop_o   (snap_pop),
    .data_o       (data_o),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

`default_nettype wire
